// ===== rtl/hrn_pkg.sv =====
// Shared widths and latencies for the Heron triangle area pipeline.
// No dependencies.
package hrn_pkg;

	localparam int COORD_W  = 16;
	localparam int FRAC_W   = 8;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int SUM_W    = 2 * COORD_W + 2;
	localparam int RAD_W    = SUM_W + 2 * FRAC_W;
	localparam int SIDE_W   = RAD_W / 2;
	localparam int P_W      = SIDE_W + 2;
	localparam int PROD_W   = 4 * P_W;
	localparam int ROOT_W   = PROD_W / 2;
	localparam int AREA_W   = 39;
	localparam int AREA_SHR = FRAC_W + 2;

	localparam int SIDE_LAT = 3 + SIDE_W;
	localparam int MUL_LAT  = 5;
	localparam int ROOT_LAT = ROOT_W;
	localparam int LAT      = SIDE_LAT + MUL_LAT + ROOT_LAT + 1;

endpackage

// ===== rtl/hrn_side.sv =====
// One triangle side: squared length, then a pipelined floor square root
// with one result bit per stage. Uses hrn_pkg.
module hrn_side (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [hrn_pkg::COORD_W-1:0]   x0,
	input  logic signed [hrn_pkg::COORD_W-1:0]   y0,
	input  logic signed [hrn_pkg::COORD_W-1:0]   x1,
	input  logic signed [hrn_pkg::COORD_W-1:0]   y1,
	output logic        [hrn_pkg::SIDE_W-1:0]    side
);

	logic signed [hrn_pkg::DIFF_W-1:0] dx, dy;
	logic [hrn_pkg::DIFF_W-1:0] adx_s1, ady_s1;
	logic [hrn_pkg::SUM_W-1:0]  sqx_s2, sqy_s2, sum_s3;

	logic [hrn_pkg::SIDE_W+1:0] rem_s  [0:hrn_pkg::SIDE_W];
	logic [hrn_pkg::SIDE_W-1:0] root_s [0:hrn_pkg::SIDE_W];
	logic [hrn_pkg::RAD_W-1:0]  rad_s  [0:hrn_pkg::SIDE_W];

	assign dx = hrn_pkg::DIFF_W'(x1) - hrn_pkg::DIFF_W'(x0);
	assign dy = hrn_pkg::DIFF_W'(y1) - hrn_pkg::DIFF_W'(y0);

	always_ff @(posedge clk) begin
		if (en) begin
			adx_s1 <= dx[hrn_pkg::DIFF_W-1] ? hrn_pkg::DIFF_W'(-dx) : hrn_pkg::DIFF_W'(dx);
			ady_s1 <= dy[hrn_pkg::DIFF_W-1] ? hrn_pkg::DIFF_W'(-dy) : hrn_pkg::DIFF_W'(dy);
			sqx_s2 <= hrn_pkg::SUM_W'(adx_s1 * adx_s1);
			sqy_s2 <= hrn_pkg::SUM_W'(ady_s1 * ady_s1);
			sum_s3 <= sqx_s2 + sqy_s2;
		end
	end

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = {sum_s3, {(2 * hrn_pkg::FRAC_W){1'b0}}};

	for (genvar k = 0; k < hrn_pkg::SIDE_W; k++) begin : g_sqrt
		logic [hrn_pkg::SIDE_W+1:0] cur, trial;
		logic ge;
		assign cur   = {rem_s[k][hrn_pkg::SIDE_W-1:0], rad_s[k][hrn_pkg::RAD_W-1 -: 2]};
		assign trial = {root_s[k], 2'b01};
		assign ge    = cur >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? cur - trial : cur;
				root_s[k+1] <= {root_s[k][hrn_pkg::SIDE_W-2:0], ge};
				rad_s[k+1]  <= rad_s[k] << 2;
			end
		end
	end

	assign side = root_s[hrn_pkg::SIDE_W];

endmodule

// ===== rtl/hrn_prod.sv =====
// Perimeter, clamped Heron factors and their 4-way product, split into
// 27x27 partial products. Uses hrn_pkg.
module hrn_prod (
	input  logic                          clk,
	input  logic                          en,
	input  logic [hrn_pkg::SIDE_W-1:0]    side_a,
	input  logic [hrn_pkg::SIDE_W-1:0]    side_b,
	input  logic [hrn_pkg::SIDE_W-1:0]    side_c,
	output logic [hrn_pkg::PROD_W-1:0]    prod,
	output logic                          clamp
);

	localparam int W2 = 2 * hrn_pkg::P_W;

	logic [hrn_pkg::P_W-1:0] p_s1, ta_s1, tb_s1, tc_s1;
	logic [hrn_pkg::P_W-1:0] p_s2, fa_s2, fb_s2, fc_s2;
	logic                    clamp_s2, clamp_s3, clamp_s4, clamp_s5;
	logic [W2-1:0]           pf_s3, gg_s3;
	logic [W2-1:0]           ll_s4, lh_s4, hl_s4, hh_s4;
	logic [hrn_pkg::PROD_W-1:0] prod_s5;
	logic ga, gb, gc;

	assign ga = p_s1 >= ta_s1;
	assign gb = p_s1 >= tb_s1;
	assign gc = p_s1 >= tc_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1  <= hrn_pkg::P_W'(side_a) + hrn_pkg::P_W'(side_b) + hrn_pkg::P_W'(side_c);
			ta_s1 <= hrn_pkg::P_W'({side_a, 1'b0});
			tb_s1 <= hrn_pkg::P_W'({side_b, 1'b0});
			tc_s1 <= hrn_pkg::P_W'({side_c, 1'b0});

			p_s2     <= p_s1;
			fa_s2    <= ga ? p_s1 - ta_s1 : '0;
			fb_s2    <= gb ? p_s1 - tb_s1 : '0;
			fc_s2    <= gc ? p_s1 - tc_s1 : '0;
			clamp_s2 <= !(ga && gb && gc);

			pf_s3    <= W2'(p_s2 * fa_s2);
			gg_s3    <= W2'(fb_s2 * fc_s2);
			clamp_s3 <= clamp_s2;

			ll_s4    <= W2'(pf_s3[hrn_pkg::P_W-1:0] * gg_s3[hrn_pkg::P_W-1:0]);
			lh_s4    <= W2'(pf_s3[hrn_pkg::P_W-1:0] * gg_s3[W2-1:hrn_pkg::P_W]);
			hl_s4    <= W2'(pf_s3[W2-1:hrn_pkg::P_W] * gg_s3[hrn_pkg::P_W-1:0]);
			hh_s4    <= W2'(pf_s3[W2-1:hrn_pkg::P_W] * gg_s3[W2-1:hrn_pkg::P_W]);
			clamp_s4 <= clamp_s3;

			prod_s5  <= (hrn_pkg::PROD_W'(hh_s4) << W2)
				+ ((hrn_pkg::PROD_W'(lh_s4) + hrn_pkg::PROD_W'(hl_s4)) << hrn_pkg::P_W)
				+ hrn_pkg::PROD_W'(ll_s4);
			clamp_s5 <= clamp_s4;
		end
	end

	assign prod  = prod_s5;
	assign clamp = clamp_s5;

endmodule

// ===== rtl/hrn_root.sv =====
// Pipelined floor square root of the 108-bit Heron product, one result
// bit per stage. Uses hrn_pkg.
module hrn_root (
	input  logic                          clk,
	input  logic                          en,
	input  logic [hrn_pkg::PROD_W-1:0]    prod,
	output logic [hrn_pkg::ROOT_W-1:0]    root
);

	logic [hrn_pkg::ROOT_W+1:0] rem_s  [0:hrn_pkg::ROOT_W];
	logic [hrn_pkg::ROOT_W-1:0] root_s [0:hrn_pkg::ROOT_W];
	logic [hrn_pkg::PROD_W-1:0] rad_s  [0:hrn_pkg::ROOT_W];

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = prod;

	for (genvar k = 0; k < hrn_pkg::ROOT_W; k++) begin : g_sqrt
		logic [hrn_pkg::ROOT_W+1:0] cur, trial;
		logic ge;
		assign cur   = {rem_s[k][hrn_pkg::ROOT_W-1:0], rad_s[k][hrn_pkg::PROD_W-1 -: 2]};
		assign trial = {root_s[k], 2'b01};
		assign ge    = cur >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? cur - trial : cur;
				root_s[k+1] <= {root_s[k][hrn_pkg::ROOT_W-2:0], ge};
				rad_s[k+1]  <= rad_s[k] << 2;
			end
		end
	end

	assign root = root_s[hrn_pkg::ROOT_W];

endmodule

// ===== rtl/triangle_area_heron.sv =====
// Triangle area by Heron's formula in fixed point: top level.
// Uses hrn_pkg, hrn_side, hrn_prod, hrn_root.
//
// Takes one triangle per clock unless stalled and returns one area per
// triangle, in order. The latency is set by the bit-per-stage square roots:
// 25 stages for each side and 54 for the final root, plus three stages of
// side arithmetic, five of factor and product arithmetic and the output
// register. The pipeline has no feedback, so throughput is one item per
// cycle; while out_stall holds back a waiting result the whole pipeline
// freezes and in_stall is raised in the same cycle.
module triangle_area_heron (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [hrn_pkg::COORD_W-1:0]   ax,
	input  logic signed [hrn_pkg::COORD_W-1:0]   ay,
	input  logic signed [hrn_pkg::COORD_W-1:0]   bx,
	input  logic signed [hrn_pkg::COORD_W-1:0]   by_coord,
	input  logic signed [hrn_pkg::COORD_W-1:0]   cx,
	input  logic signed [hrn_pkg::COORD_W-1:0]   cy,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [hrn_pkg::AREA_W-1:0]           area_q8,
	output logic                                 clamped
);

	logic en;
	logic [hrn_pkg::LAT-1:0] vld_q;
	logic [hrn_pkg::SIDE_W-1:0] side_a, side_b, side_c;
	logic [hrn_pkg::PROD_W-1:0] prod;
	logic clamp;
	logic [hrn_pkg::ROOT_W-1:0] root;
	logic [hrn_pkg::ROOT_LAT-1:0] clamp_q;

	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_q[hrn_pkg::LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[hrn_pkg::LAT-2:0], in_valid};
		end
	end

	hrn_side u_side_a (.clk, .en, .x0(ax), .y0(ay), .x1(bx), .y1(by_coord), .side(side_a));
	hrn_side u_side_b (.clk, .en, .x0(bx), .y0(by_coord), .x1(cx), .y1(cy), .side(side_b));
	hrn_side u_side_c (.clk, .en, .x0(cx), .y0(cy), .x1(ax), .y1(ay), .side(side_c));

	hrn_prod u_prod (.clk, .en, .side_a, .side_b, .side_c, .prod, .clamp);

	hrn_root u_root (.clk, .en, .prod, .root);

	always_ff @(posedge clk) begin
		if (en) begin
			clamp_q <= {clamp_q[hrn_pkg::ROOT_LAT-2:0], clamp};
			area_q8 <= hrn_pkg::AREA_W'(root >> hrn_pkg::AREA_SHR);
			clamped <= clamp_q[hrn_pkg::ROOT_LAT-1];
		end
	end

	a_clamp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clamped |-> area_q8 == '0)
		else $error("clamped result with nonzero area");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(vld_q))
		else $error("pipeline moved while output stalled");

endmodule
